// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, ignored while reset is asserted.
`define FTC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define FTC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/ftc_pkg.sv -----
package ftc_pkg;

    localparam int TRAILER_BYTES = 40;
    localparam int MAGIC_END     = 8;
    localparam int OFFSET_END    = 16;
    localparam int LENGTH_END    = 24;
    localparam int FCRC_END      = 28;
    localparam int FILE_END      = 32;
    localparam int STORED_END    = 36;
    localparam int CRC_SPAN      = 32;
    localparam int COUNT_W       = 6;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SIZE     = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_RESERVED = 3'd3,
        ST_CRC      = 3'd4
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [63:0] foot_ofs;
        logic [63:0] foot_len;
        logic [31:0] foot_crc;
        logic [31:0] whole_crc;
    } t_result;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } t_buf_status;

    // Reflected CRC-32C over one byte, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            crc = (crc >> 1) ^ (CRC_POLY & {32{crc[0]}});
        end
        return crc;
    endfunction

endpackage

// ----- hw/rtl/ftc_accum.sv -----
`include "assert_macros.svh"

module ftc_accum import ftc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_magic,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic        o_push,
    output t_result     o_result
);

    t_count      r_byte_count, n_byte_count;
    logic [31:0] r_crc, n_crc;
    logic        r_magic_bad, n_magic_bad;
    logic [63:0] r_offset, n_offset;
    logic [63:0] r_length, n_length;
    logic [31:0] r_fcrc, n_fcrc;
    logic [31:0] r_filecrc, n_filecrc;
    logic [31:0] r_stored, n_stored;
    logic        r_rsvd_bad, n_rsvd_bad;
    t_count      pos;
    t_status     status;

    assign pos = r_byte_count;

    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_magic_bad  = r_magic_bad;
        n_offset     = r_offset;
        n_length     = r_length;
        n_fcrc       = r_fcrc;
        n_filecrc    = r_filecrc;
        n_stored     = r_stored;
        n_rsvd_bad   = r_rsvd_bad;

        if (pos < COUNT_W'(MAGIC_END)) begin
            if (i_magic[{pos[2:0], 3'b000} +: 8] != i_byte) begin
                n_magic_bad = 1'b1;
            end
        end else if (pos < COUNT_W'(OFFSET_END)) begin
            n_offset = {i_byte, r_offset[63:8]};
        end else if (pos < COUNT_W'(LENGTH_END)) begin
            n_length = {i_byte, r_length[63:8]};
        end else if (pos < COUNT_W'(FCRC_END)) begin
            n_fcrc = {i_byte, r_fcrc[31:8]};
        end else if (pos < COUNT_W'(FILE_END)) begin
            n_filecrc = {i_byte, r_filecrc[31:8]};
        end else if (pos < COUNT_W'(STORED_END)) begin
            n_stored = {i_byte, r_stored[31:8]};
        end else if (pos < COUNT_W'(TRAILER_BYTES)) begin
            if (i_byte != 8'd0) begin
                n_rsvd_bad = 1'b1;
            end
        end

        if (pos < COUNT_W'(CRC_SPAN)) begin
            n_crc = crc_byte(r_crc, i_byte);
        end
        if (pos < COUNT_W'(TRAILER_BYTES + 1)) begin
            n_byte_count = pos + COUNT_W'(1);
        end
    end

    // Checks in priority order on the updated state.
    always_comb begin
        if (n_byte_count != COUNT_W'(TRAILER_BYTES)) begin
            status = ST_SIZE;
        end else if (n_magic_bad) begin
            status = ST_MAGIC;
        end else if (n_rsvd_bad) begin
            status = ST_RESERVED;
        end else if ((n_crc ^ CRC_INIT) != n_stored) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end
    end

    assign o_push = i_byte_valid && i_last;

    always_comb begin
        o_result.status    = status;
        o_result.foot_ofs  = (status == ST_OK) ? n_offset  : 64'd0;
        o_result.foot_len  = (status == ST_OK) ? n_length  : 64'd0;
        o_result.foot_crc  = (status == ST_OK) ? n_fcrc    : 32'd0;
        o_result.whole_crc = (status == ST_OK) ? n_filecrc : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_byte_count <= '0;
            r_crc        <= CRC_INIT;
            r_magic_bad  <= 1'b0;
            r_offset     <= '0;
            r_length     <= '0;
            r_fcrc       <= '0;
            r_filecrc    <= '0;
            r_stored     <= '0;
            r_rsvd_bad   <= 1'b0;
        end else if (i_byte_valid) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_magic_bad  <= n_magic_bad;
            r_offset     <= n_offset;
            r_length     <= n_length;
            r_fcrc       <= n_fcrc;
            r_filecrc    <= n_filecrc;
            r_stored     <= n_stored;
            r_rsvd_bad   <= n_rsvd_bad;
        end
    end

    `FTC_NEVER(a_count_range, i_clk, i_rst_n,
        r_byte_count > COUNT_W'(TRAILER_BYTES + 1), "byte count past saturation")
    `FTC_ASSERT(a_clear_after_last, i_clk, i_rst_n,
        o_push |=> (r_byte_count == '0 && r_crc == CRC_INIT), "state not cleared after last word")

endmodule

// ----- hw/rtl/ftc_outbuf.sv -----
`include "assert_macros.svh"

module ftc_outbuf import ftc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result     i_result,
    input  logic        i_stall,
    output logic        o_valid,
    output t_result     o_result,
    output t_buf_status o_buf
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // Advance the held word once the head is taken.
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result         = r_out;
    assign o_buf.out_valid  = r_out_valid;
    assign o_buf.skid_valid = r_skid_valid;

    `FTC_NEVER(a_push_into_full, i_clk, i_rst_n, i_push && r_skid_valid, "result pushed into full buffer")
    `FTC_NEVER(a_skid_without_head, i_clk, i_rst_n, r_skid_valid && !r_out_valid, "skid word held without head word")

endmodule

// ----- hw/rtl/file_trailer_checker_unit.sv -----
// File trailer checker.
// Input channel: one trailer byte per word (i_data_byte), with i_last_byte set
// on the final byte. A word is taken at a rising edge with i_valid high and
// o_stall low. Each last byte gives one result word (status is a size error
// unless it ends exactly 40 bytes): status plus the decoded footer offset,
// length, footer checksum and file checksum (all zero unless status is ok).
// The CRC-32C of the first 32 bytes is checked against the stored trailer CRC.
// Output channel: a word is taken at a rising edge with o_valid high and
// i_stall low. Bytes without the last flag give no result.
// A byte enters the input register at the edge that takes it; the result of
// a last byte enters the result buffer at the next edge. Throughput: one byte
// per cycle while o_stall is low; the CRC step for a byte is unrolled over
// its eight bits. A two-word result buffer absorbs downstream stall; o_stall
// is high while the buffer is full, and while i_stall holds its head word and
// the byte in the input register is a last byte whose result will take the
// second slot.
// The user writes the magic register (i_cfg_wr_en/i_cfg_wr_data) only while
// idle; the block does not enforce it. Reset (synchronous, active low) clears
// the magic to zero, drops all pending words and restarts byte count and CRC.

`include "assert_macros.svh"

module file_trailer_checker_unit import ftc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_foot_ofs,
    output logic [63:0] o_foot_len,
    output logic [31:0] o_foot_crc,
    output logic [31:0] o_whole_crc
);

    logic [63:0] r_magic;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        in_accept;
    logic        push;
    t_result     acc_result;
    t_result     out_result;
    t_buf_status buf_st;

    // Hold the expected magic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= '0;
        end else if (i_cfg_wr_en) begin
            r_magic <= i_cfg_wr_data;
        end
    end

    // Stall when the buffer is full, or when it holds one word that is not
    // leaving and the byte in the input register will produce another.
    assign o_stall = buf_st.skid_valid ||
                     (buf_st.out_valid && r_in_valid && r_in_last && i_stall);
    assign in_accept = i_valid && !o_stall;

    // Input register: every held byte is processed in the next cycle, the
    // stall logic above guarantees the result buffer has room for it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    ftc_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_magic      (r_magic),
        .i_byte_valid (r_in_valid),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .o_push       (push),
        .o_result     (acc_result)
    );

    ftc_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (acc_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (out_result),
        .o_buf    (buf_st)
    );

    assign o_status    = out_result.status;
    assign o_foot_ofs  = out_result.foot_ofs;
    assign o_foot_len  = out_result.foot_len;
    assign o_foot_crc  = out_result.foot_crc;
    assign o_whole_crc = out_result.whole_crc;

    // A last byte taken must be on the output after the following edge.
    `FTC_ASSERT(a_last_gives_result, i_clk, i_rst_n,
        (in_accept && i_last_byte) |=> ##1 o_valid, "last word produced no result")

endmodule
